/* hdl/slik_pkg.sv */
package slik_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;

  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]         pos_t;

  // item kinds
  localparam kind_t KIND_APPEND = 2'd0;
  localparam kind_t KIND_ADJUST = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  // command handed from the front to the back through the queue
  typedef struct packed {
    kind_t op;
    data_t value;
    pos_t  position;
    data_t amount;
  } cmd_t;

  // signed add clamped to the 32-bit range
  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

/* hdl/slik_in_if.sv */
interface slik_in_if;
  import slik_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  data_t value;
  pos_t  position;
  data_t amount;

  modport source(output valid, kind, value, position, amount, input ready);
  modport sink(input valid, kind, value, position, amount, output ready);
endinterface

/* hdl/slik_out_if.sv */
interface slik_out_if;
  import slik_pkg::*;

  logic  valid;
  logic  ready;
  data_t element;
  logic  last;

  modport source(output valid, element, last, input ready);
  modport sink(input valid, element, last, output ready);
endinterface

/* hdl/slik_front.sv */
module slik_front (
  slik_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output slik_pkg::cmd_t   q_cmd
);
  import slik_pkg::*;

  logic known_kind;

  // unused kind code is taken and dropped here
  assign known_kind = (in_ch.kind == KIND_APPEND) || (in_ch.kind == KIND_ADJUST) ||
                      (in_ch.kind == KIND_CLEAR);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && known_kind;

  always_comb begin
    q_cmd.op       = in_ch.kind;
    q_cmd.value    = in_ch.value;
    q_cmd.position = in_ch.position;
    q_cmd.amount   = in_ch.amount;
  end

endmodule

/* hdl/slik_queue.sv */
module slik_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slik_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output slik_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import slik_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/slik_back.sv */
module slik_back #(
  parameter int LIST_DEPTH = slik_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  slik_pkg::cmd_t q_cmd,
  output logic           q_pop,
  slik_out_if.source     out_ch
);
  import slik_pkg::*;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = POS_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_EMRD = 3'd3;
  localparam logic [2:0] S_EMLD = 3'd4;

  data_t mem [LIST_DEPTH];
  data_t rdata_r;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  data_t            nv_r, nv_nxt;
  data_t            amt_r, amt_nxt;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  data_t            wr_data;

  logic             out_valid_r, out_last_r;
  data_t            out_elem_r;
  logic             ld_out, out_free, last_i;

  assign out_free = !out_valid_r || out_ch.ready;
  assign last_i   = (CNT_W'(i_r) + CNT_W'(1) == count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    nv_nxt    = nv_r;
    amt_nxt   = amt_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    q_pop     = 1'b0;
    ld_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            KIND_APPEND: begin
              if (count_r < CNT_W'(LIST_DEPTH)) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IDX_W-1:0];
                wr_data   = q_cmd.value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_ADJUST: begin
              amt_nxt = q_cmd.amount;
              if (CMP_W'(q_cmd.position) < CMP_W'(count_r)) begin
                j_nxt     = q_cmd.position[IDX_W-1:0];
                rd_en     = 1'b1;
                rd_addr   = q_cmd.position[IDX_W-1:0];
                state_nxt = S_LOAD;
              end else if (count_r != '0) begin
                state_nxt = S_EMRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        nv_nxt    = sat_add(rdata_r, amt_r);
        state_nxt = S_WALK;
        if (CNT_W'(j_r) + CNT_W'(1) < count_r) begin
          rd_en   = 1'b1;
          rd_addr = j_r + IDX_W'(1);
        end
      end
      S_WALK: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        if ((CNT_W'(j_r) + CNT_W'(1) < count_r) && (rdata_r < nv_r)) begin
          wr_data = rdata_r;
          j_nxt   = j_r + IDX_W'(1);
          if (CNT_W'(j_r) + CNT_W'(2) < count_r) begin
            rd_en   = 1'b1;
            rd_addr = j_r + IDX_W'(2);
          end
        end else begin
          wr_data   = nv_r;
          state_nxt = S_EMRD;
        end
      end
      S_EMRD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        i_nxt     = '0;
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        if (out_free) begin
          ld_out = 1'b1;
          if (last_i) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt   = i_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = i_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    i_r   <= i_nxt;
    nv_r  <= nv_nxt;
    amt_r <= amt_nxt;
    if (ld_out) begin
      out_elem_r <= rdata_r;
      out_last_r <= last_i;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.element = out_elem_r;
  assign out_ch.last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CNT_W'(j_r) < count_r))
    else $error("walk index outside the list");

  a_busy_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (count_r == $past(count_r)))
    else $error("entry count changed during an adjust");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMLD) |-> ((count_r != '0) && (CNT_W'(i_r) < count_r)))
    else $error("emit index outside the list");

endmodule

/* hdl/sorted_list_increase_key_unit.sv */
// sorted list with key increase
//
// in_ch carries items: kind append writes value at the tail (dropped when the
// list is full), kind clear empties the list, kind adjust adds amount to the
// entry at position (saturating), moves it toward the tail past every later
// entry that is strictly smaller, then emits the whole list on out_ch head to
// tail with last on the final entry. an adjust on an empty list emits nothing,
// an adjust with position at or past the count emits the list unchanged.
// the unused kind code is accepted and ignored.
// the front takes items into a two-entry queue whenever it has room, so an
// item is accepted while earlier work is still running or a result waits.
// the back runs one command at a time on an entry memory with one write port and
// one registered read port: append or clear finish as they are popped; an adjust
// fetches and sums the entry, writes back each later entry it passes, places the
// entry, then streams the list, one entry per cycle while out_ch.ready stays high.
// results pass through the queue, the back and the out_ch output register.
// out_ch has an output register; a stall on out_ch holds it and pauses the
// emit walk, and the queue fills and drops in_ch.ready behind it.
// synchronous active-low reset empties the list and the queue; entry memory
// itself is not cleared.
module sorted_list_increase_key_unit #(
  parameter int LIST_DEPTH = slik_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slik_in_if.sink    in_ch,
  slik_out_if.source out_ch
);
  import slik_pkg::*;

  // front to queue
  logic q_push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic q_pop;
  cmd_t pop_cmd;
  logic q_empty;

  // accept and classify items
  slik_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // decouples acceptance from list work
  slik_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // list store, adjust walk and emit
  slik_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* verif/tb_top.sv */
module tb_top;
  import slik_pkg::*;

  localparam int    LIST_DEPTH  = 64;
  localparam int    ITEM_GOAL   = 380;    // accepted items, ignored ones not counted
  localparam int    PHASE_ITEMS = 89;     // random items per idling phase
  localparam int    DRAIN_WAIT  = 150;    // an adjust on a full list plus queue slack
  localparam int    HOLD_CYCLES = 400;    // long receiver hold-off
  localparam kind_t KIND_UNUSED = 2'd3;   // accepted and ignored by the block
  localparam data_t DATA_MAX    = 32'sh7fff_ffff;
  localparam data_t DATA_MIN    = 32'sh8000_0000;
  localparam logic signed [7:0] FROM_MODEL = -8'sd1;

  // one emitted list entry as the receiver should see it
  typedef struct packed {
    data_t element;
    logic  last;
  } emit_t;

  // directed stimulus row; fixed_n < 0 means the predictor supplies the list,
  // otherwise fixed_n entries are expected (0 or 1, the single one being fixed_elem)
  typedef struct packed {
    kind_t             kind;
    data_t             value;
    pos_t              position;
    data_t             amount;
    logic signed [7:0] fixed_n;
    data_t             fixed_elem;
  } row_t;

  localparam int DIR_ROWS = 25;
  localparam row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // adjust right after reset: empty list, nothing emitted
    '{KIND_ADJUST, 32'sd0, 6'd0, 32'sd0, 8'sd0, 32'sd0},
    '{KIND_APPEND, DATA_MAX, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    // sum saturates high, then max + min, then saturates low
    '{KIND_ADJUST, 32'sd0, 6'd0, DATA_MAX, 8'sd1, DATA_MAX},
    '{KIND_ADJUST, 32'sd0, 6'd0, DATA_MIN, 8'sd1, -32'sd1},
    '{KIND_ADJUST, 32'sd0, 6'd0, DATA_MIN, 8'sd1, DATA_MIN},
    '{KIND_CLEAR, 32'sd0, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    // cleared list, top position: still nothing emitted
    '{KIND_ADJUST, 32'sd0, 6'd63, 32'sd0, 8'sd0, 32'sd0},
    '{KIND_APPEND, DATA_MIN, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, 32'sd0, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, 32'sd5, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, -32'sd3, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    // head stays put, then a middle entry walks past two smaller ones
    '{KIND_ADJUST, 32'sd0, 6'd0, 32'sd10, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd1, 32'sd6, FROM_MODEL, 32'sd0},
    // positions past the count leave the list alone but still emit it
    '{KIND_ADJUST, 32'sd0, 6'd63, 32'sd1, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd4, -32'sd1, FROM_MODEL, 32'sd0},
    '{KIND_UNUSED, 32'sh5555_5555, 6'd42, 32'shaaaa_aaaa, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd2, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, 32'sh5555_5555, 6'd21, 32'shaaaa_aaaa, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, 32'shaaaa_aaaa, 6'd42, 32'sh5555_5555, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd21, DATA_MAX, FROM_MODEL, 32'sd0},
    // saturated entry walks all the way to the tail
    '{KIND_ADJUST, 32'sd0, 6'd3, DATA_MAX, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd5, DATA_MIN, FROM_MODEL, 32'sd0},
    '{KIND_CLEAR, 32'sd0, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_APPEND, -32'sd1, 6'd0, 32'sd0, FROM_MODEL, 32'sd0},
    '{KIND_ADJUST, 32'sd0, 6'd0, 32'sd1, 8'sd1, 32'sd0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  slik_in_if  in_ch ();
  slik_out_if out_ch ();

  sorted_list_increase_key_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted list contents and the entries still owed by the block
  data_t       list_mem [LIST_DEPTH];
  int unsigned list_len;
  emit_t       pending_entries [$];

  int unsigned items_taken;     // accepted items that are not ignored
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  logic        hold_rx = 1'b0;
  int unsigned errors = 0;

  // signed sum clamped to the 32-bit range
  function automatic data_t clamp_sum(input data_t a, input data_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(DATA_MAX)) return DATA_MAX;
    if (s < longint'(DATA_MIN)) return DATA_MIN;
    return data_t'(s);
  endfunction

  // advance the predicted list by one accepted item
  function automatic void list_apply(input kind_t kind, input data_t value,
                                     input pos_t position, input data_t amount);
    int unsigned j;
    data_t       moved;
    case (kind)
      KIND_APPEND: begin
        // a full list drops the append
        if (list_len < LIST_DEPTH) begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      KIND_CLEAR: begin
        list_len = 0;
      end
      KIND_ADJUST: begin
        if (position < list_len) begin
          moved = clamp_sum(list_mem[position], amount);
          j = position;
          // shift later entries that are strictly smaller one step toward the head
          while (j + 1 < list_len && list_mem[j+1] < moved) begin
            list_mem[j] = list_mem[j+1];
            j++;
          end
          list_mem[j] = moved;
        end
      end
      default: ;
    endcase
  endfunction

  // offer one item, wait for acceptance, then record what the block owes for it
  task automatic offer_item(input kind_t kind, input data_t value, input pos_t position,
                            input data_t amount, input logic signed [7:0] fixed_n,
                            input data_t fixed_elem);
    emit_t e;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.value    <= value;
    in_ch.position <= position;
    in_ch.amount   <= amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    list_apply(kind, value, position, amount);
    if (kind != KIND_UNUSED) items_taken++;
    if (kind == KIND_ADJUST) begin
      if (fixed_n >= 0) begin
        // typed-in expectation for the rows that read off at a glance
        if (fixed_n > 0) begin
          e.element = fixed_elem;
          e.last    = 1'b1;
          pending_entries.insert(pending_entries.size(), e);
        end
      end else begin
        for (int i = 0; i < list_len; i++) begin
          e.element = list_mem[i];
          e.last    = (i + 1 == list_len);
          pending_entries.insert(pending_entries.size(), e);
        end
      end
    end
  endtask

  task automatic offer_random(input kind_t kind, input data_t value, input pos_t position,
                              input data_t amount);
    offer_item(kind, value, position, amount, FROM_MODEL, 32'sd0);
  endtask

  // idling phases: none, sender idle, receiver stalling, both
  task automatic set_phase();
    int unsigned phase;
    phase = (items_taken > DIR_ROWS) ? (items_taken - DIR_ROWS) / PHASE_ITEMS : 0;
    case (phase)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 58; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 58; end
      default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
    endcase
  endtask

  function automatic data_t pick_amount();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 12) return data_t'($urandom_range(60));        // key increase, the usual use
    if (r < 14) return -data_t'($urandom_range(60, 1));
    if (r < 17) return data_t'($urandom);
    if (r == 17) return DATA_MAX;
    if (r == 18) return DATA_MIN;
    return 32'sd0;
  endfunction

  function automatic pos_t pick_position();
    if (list_len > 0 && $urandom_range(9) != 0) return pos_t'($urandom_range(list_len - 1));
    return pos_t'($urandom_range(63));
  endfunction

  // random part: episodes of clear, ascending appends with some noise, then adjusts
  task automatic run_episodes();
    int unsigned ep;
    int unsigned n_app;
    int unsigned n_adj;
    data_t       run_val;
    ep = 0;
    while (items_taken < ITEM_GOAL) begin
      set_phase();
      if ($urandom_range(9) != 0) offer_random(KIND_CLEAR, data_t'($urandom), 6'd0, 32'sd0);
      // a few episodes overfill the list so appends get dropped
      n_app = (ep % 14 == 2) ? LIST_DEPTH + $urandom_range(3) : $urandom_range(12, 1);
      n_adj = (ep % 14 == 2) ? 4 : $urandom_range(5, 1);
      run_val = $urandom_range(1) ? data_t'($urandom) : data_t'($urandom_range(200)) - 100;
      for (int k = 0; k < n_app; k++) begin
        if ($urandom_range(3) == 0) begin
          offer_random(KIND_APPEND, data_t'($urandom), pos_t'($urandom), data_t'($urandom));
        end else begin
          offer_random(KIND_APPEND, run_val, pos_t'($urandom), data_t'($urandom));
          run_val = run_val + data_t'($urandom_range(20));
        end
      end
      for (int k = 0; k < n_adj; k++) begin
        case ($urandom_range(19))
          0:       offer_random(KIND_UNUSED, data_t'($urandom), pos_t'($urandom),
                                data_t'($urandom));
          1:       offer_random(KIND_APPEND, data_t'($urandom), pos_t'($urandom),
                                data_t'($urandom));
          default: offer_random(KIND_ADJUST, data_t'($urandom), pick_position(),
                                pick_amount());
        endcase
      end
      ep++;
    end
  endtask

  // receiver: random stalls plus the long hold-off, and the result check
  always @(posedge clk) begin
    emit_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_entries.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual element %0d last %0b",
                   $time, out_ch.element, out_ch.last);
          errors++;
        end else begin
          want = pending_entries.pop_front();
          if (out_ch.element !== want.element) begin
            $display("%0t: element mismatch: expected %0d, actual %0d",
                     $time, want.element, out_ch.element);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_ch.last);
            errors++;
          end
        end
      end
    end
  end

  // long receiver hold-off early in the unthrottled phase, so the queue backs up
  initial begin
    while (items_taken < DIR_ROWS + 40) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_APPEND;
    in_ch.value    = 32'sd0;
    in_ch.position = 6'd0;
    in_ch.amount   = 32'sd0;
    list_len       = 0;
    items_taken    = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_item(DIR_TABLE[r].kind, DIR_TABLE[r].value, DIR_TABLE[r].position,
                 DIR_TABLE[r].amount, DIR_TABLE[r].fixed_n, DIR_TABLE[r].fixed_elem);
    end
    run_episodes();

    in_ch.valid <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (pending_entries.size() != 0) @(posedge clk);
    // stray items from a late adjust would show up here
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
